// ===== src/qslerp_pkg.sv =====
// ----------------------------------------------------------------------------
// qslerp_pkg: shared types and constants for the quaternion slerp pipeline
// Fixed-point formats, CORDIC arctangent table and pipeline stage counts.
// ----------------------------------------------------------------------------
package qslerp_pkg;

	localparam int COMPONENT_WIDTH = 16;
	localparam int CW              = COMPONENT_WIDTH;
	localparam int BLEND_WIDTH     = 19;
	localparam int CORDIC_STEPS    = 16;
	localparam int FRAC            = 30;
	localparam int VW              = 34;
	localparam int DOT_W           = FRAC + 6;
	localparam int SQ_STEPS        = 32;
	localparam int DIV_STEPS       = FRAC + 1;
	localparam int DIV_LAT         = DIV_STEPS + 1;
	localparam int THR_W           = 16;

	typedef logic signed [VW-1:0] cval_t;
	typedef logic [FRAC:0]        wgt_t;
	typedef logic [16:0]          blend_t;

	// Operands that travel beside the trigonometric datapath.
	typedef struct packed {
		logic [3:0][CW-1:0] a;
		logic [3:0][CW:0]   b;
		blend_t             t;
		logic               lin;
	} side_t;

	localparam logic [THR_W-1:0] THRESH_RESET = 16'd32752;
	localparam blend_t           BLEND_ONE    = 17'h10000;
	localparam cval_t            ONE_Q30      = cval_t'(1) <<< FRAC;
	localparam wgt_t             ONE_W        = wgt_t'(1) << FRAC;
	localparam cval_t            SIN_FLOOR    = cval_t'(1) <<< (FRAC - 14);

	// Arctangent of 2^-i in Q2.30; below the table the angle equals the shift.
	function automatic cval_t atan_step(input int i);
		cval_t r;
		case (i)
			0:       r = cval_t'(843314857);
			1:       r = cval_t'(497837829);
			2:       r = cval_t'(263043837);
			3:       r = cval_t'(133525159);
			4:       r = cval_t'(67021687);
			5:       r = cval_t'(33543516);
			6:       r = cval_t'(16775851);
			7:       r = cval_t'(8388437);
			8:       r = cval_t'(4194283);
			9:       r = cval_t'(2097149);
			default: r = (i <= FRAC) ? (cval_t'(1) <<< (FRAC - i)) : '0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/qslerp_sqrt.sv =====
// ----------------------------------------------------------------------------
// qslerp_sqrt: pipelined integer square root
// One result bit per stage, SQ_STEPS stages from operand to root.
// ----------------------------------------------------------------------------
module qslerp_sqrt (
	input  logic                clk,
	input  logic                en,
	input  logic [60:0]         rest,
	output qslerp_pkg::wgt_t    root
);
	import qslerp_pkg::*;

	logic [63:0] rem_c  [SQ_STEPS];
	logic [63:0] root_c [SQ_STEPS];
	logic [63:0] rem_n  [SQ_STEPS-1];
	logic [63:0] root_n [SQ_STEPS];
	logic [63:0] rem_s  [SQ_STEPS-1];
	logic [63:0] root_s [SQ_STEPS];

	always_comb begin
		rem_c[0]  = 64'(rest);
		root_c[0] = '0;
		for (int i = 1; i < SQ_STEPS; i++) begin
			rem_c[i]  = rem_s[i-1];
			root_c[i] = root_s[i-1];
		end
		for (int i = 0; i < SQ_STEPS; i++) begin
			if (rem_c[i] >= root_c[i] + (64'd1 << (62 - 2 * i))) begin
				root_n[i] = (root_c[i] >> 1) + (64'd1 << (62 - 2 * i));
			end else begin
				root_n[i] = root_c[i] >> 1;
			end
		end
		for (int i = 0; i < SQ_STEPS - 1; i++) begin
			if (rem_c[i] >= root_c[i] + (64'd1 << (62 - 2 * i))) begin
				rem_n[i] = rem_c[i] - (root_c[i] + (64'd1 << (62 - 2 * i)));
			end else begin
				rem_n[i] = rem_c[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < SQ_STEPS; i++) root_s[i] <= root_n[i];
			for (int i = 0; i < SQ_STEPS - 1; i++) rem_s[i] <= rem_n[i];
		end
	end

	assign root = root_s[SQ_STEPS-1][FRAC:0];

endmodule

// ===== src/qslerp_cordic_vec.sv =====
// ----------------------------------------------------------------------------
// qslerp_cordic_vec: pipelined vectoring CORDIC
// Drives y towards zero and accumulates the angle, one iteration per stage.
// ----------------------------------------------------------------------------
module qslerp_cordic_vec (
	input  logic                clk,
	input  logic                en,
	input  qslerp_pkg::cval_t   x_in,
	input  qslerp_pkg::cval_t   y_in,
	output qslerp_pkg::cval_t   z_out
);
	import qslerp_pkg::*;

	cval_t x_c [CORDIC_STEPS];
	cval_t y_c [CORDIC_STEPS];
	cval_t z_c [CORDIC_STEPS];
	cval_t x_n [CORDIC_STEPS-1];
	cval_t y_n [CORDIC_STEPS-1];
	cval_t z_n [CORDIC_STEPS];
	cval_t x_s [CORDIC_STEPS-1];
	cval_t y_s [CORDIC_STEPS-1];
	cval_t z_s [CORDIC_STEPS];

	always_comb begin
		x_c[0] = x_in;
		y_c[0] = y_in;
		z_c[0] = '0;
		for (int i = 1; i < CORDIC_STEPS; i++) begin
			x_c[i] = x_s[i-1];
			y_c[i] = y_s[i-1];
			z_c[i] = z_s[i-1];
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			z_n[i] = (y_c[i] >= 0) ? z_c[i] + atan_step(i) : z_c[i] - atan_step(i);
		end
		for (int i = 0; i < CORDIC_STEPS - 1; i++) begin
			if (y_c[i] >= 0) begin
				x_n[i] = x_c[i] + (y_c[i] >>> i);
				y_n[i] = y_c[i] - (x_c[i] >>> i);
			end else begin
				x_n[i] = x_c[i] - (y_c[i] >>> i);
				y_n[i] = y_c[i] + (x_c[i] >>> i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < CORDIC_STEPS; i++) z_s[i] <= z_n[i];
			for (int i = 0; i < CORDIC_STEPS - 1; i++) begin
				x_s[i] <= x_n[i];
				y_s[i] <= y_n[i];
			end
		end
	end

	assign z_out = z_s[CORDIC_STEPS-1];

endmodule

// ===== src/qslerp_cordic_rot.sv =====
// ----------------------------------------------------------------------------
// qslerp_cordic_rot: pipelined rotation CORDIC
// Rotates the unit vector by the given angle and returns the scaled sine.
// ----------------------------------------------------------------------------
module qslerp_cordic_rot (
	input  logic                clk,
	input  logic                en,
	input  qslerp_pkg::cval_t   z_in,
	output qslerp_pkg::cval_t   sin_out
);
	import qslerp_pkg::*;

	cval_t x_c [CORDIC_STEPS];
	cval_t y_c [CORDIC_STEPS];
	cval_t z_c [CORDIC_STEPS];
	cval_t x_n [CORDIC_STEPS-1];
	cval_t y_n [CORDIC_STEPS];
	cval_t z_n [CORDIC_STEPS-1];
	cval_t x_s [CORDIC_STEPS-1];
	cval_t y_s [CORDIC_STEPS];
	cval_t z_s [CORDIC_STEPS-1];

	always_comb begin
		x_c[0] = ONE_Q30;
		y_c[0] = '0;
		z_c[0] = z_in;
		for (int i = 1; i < CORDIC_STEPS; i++) begin
			x_c[i] = x_s[i-1];
			y_c[i] = y_s[i-1];
			z_c[i] = z_s[i-1];
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			y_n[i] = (z_c[i] >= 0) ? y_c[i] + (x_c[i] >>> i) : y_c[i] - (x_c[i] >>> i);
		end
		for (int i = 0; i < CORDIC_STEPS - 1; i++) begin
			if (z_c[i] >= 0) begin
				x_n[i] = x_c[i] - (y_c[i] >>> i);
				z_n[i] = z_c[i] - atan_step(i);
			end else begin
				x_n[i] = x_c[i] + (y_c[i] >>> i);
				z_n[i] = z_c[i] + atan_step(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < CORDIC_STEPS; i++) y_s[i] <= y_n[i];
			for (int i = 0; i < CORDIC_STEPS - 1; i++) begin
				x_s[i] <= x_n[i];
				z_s[i] <= z_n[i];
			end
		end
	end

	assign sin_out = y_s[CORDIC_STEPS-1];

endmodule

// ===== src/qslerp_div.sv =====
// ----------------------------------------------------------------------------
// qslerp_div: pipelined rounding weight divider
// Computes round(num / den) in Q2.30, clamped to [0, 1.0], one bit per stage.
// ----------------------------------------------------------------------------
module qslerp_div (
	input  logic                clk,
	input  logic                en,
	input  qslerp_pkg::cval_t   num,
	input  qslerp_pkg::cval_t   den,
	output qslerp_pkg::wgt_t    quo
);
	import qslerp_pkg::*;

	logic [63:0] pre_num;
	logic [63:0] pre_rem_s;
	logic [31:0] pre_den_s;
	logic        pre_zero_s;
	logic        pre_ovf_s;

	logic [63:0] rem_c  [DIV_STEPS];
	logic [31:0] den_c  [DIV_STEPS];
	wgt_t        quo_c  [DIV_STEPS];
	logic        zero_c [DIV_STEPS];
	logic        ovf_c  [DIV_STEPS];
	logic [63:0] rem_n  [DIV_STEPS-1];
	wgt_t        quo_n  [DIV_STEPS];
	logic [63:0] rem_s  [DIV_STEPS-1];
	logic [31:0] den_s  [DIV_STEPS-1];
	wgt_t        quo_s  [DIV_STEPS];
	logic        zero_s [DIV_STEPS];
	logic        ovf_s  [DIV_STEPS];

	// Numerator scaled by 2^30 with half the divisor added for rounding.
	assign pre_num = (64'($unsigned(num)) << FRAC) + 64'(den[31:1]);

	always_ff @(posedge clk) begin
		if (en) begin
			pre_rem_s  <= pre_num;
			pre_den_s  <= den[31:0];
			pre_zero_s <= (num <= 0);
			pre_ovf_s  <= (pre_num >= (64'(den[31:0]) << DIV_STEPS));
		end
	end

	always_comb begin
		rem_c[0]  = pre_rem_s;
		den_c[0]  = pre_den_s;
		quo_c[0]  = '0;
		zero_c[0] = pre_zero_s;
		ovf_c[0]  = pre_ovf_s;
		for (int j = 1; j < DIV_STEPS; j++) begin
			rem_c[j]  = rem_s[j-1];
			den_c[j]  = den_s[j-1];
			quo_c[j]  = quo_s[j-1];
			zero_c[j] = zero_s[j-1];
			ovf_c[j]  = ovf_s[j-1];
		end
		for (int j = 0; j < DIV_STEPS; j++) begin
			if (rem_c[j] >= (64'(den_c[j]) << (FRAC - j))) begin
				quo_n[j] = quo_c[j] | (wgt_t'(1) << (FRAC - j));
			end else begin
				quo_n[j] = quo_c[j];
			end
		end
		for (int j = 0; j < DIV_STEPS - 1; j++) begin
			if (rem_c[j] >= (64'(den_c[j]) << (FRAC - j))) begin
				rem_n[j] = rem_c[j] - (64'(den_c[j]) << (FRAC - j));
			end else begin
				rem_n[j] = rem_c[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < DIV_STEPS; j++) begin
				quo_s[j]  <= quo_n[j];
				zero_s[j] <= zero_c[j];
				ovf_s[j]  <= ovf_c[j];
			end
			for (int j = 0; j < DIV_STEPS - 1; j++) begin
				rem_s[j] <= rem_n[j];
				den_s[j] <= den_c[j];
			end
		end
	end

	always_comb begin
		if (zero_s[DIV_STEPS-1]) begin
			quo = '0;
		end else if (ovf_s[DIV_STEPS-1] || quo_s[DIV_STEPS-1] > ONE_W) begin
			quo = ONE_W;
		end else begin
			quo = quo_s[DIV_STEPS-1];
		end
	end

endmodule

// ===== src/quaternion_slerp.sv =====
// ----------------------------------------------------------------------------
// quaternion_slerp: pipelined spherical linear interpolation of quaternions
// Blends two Q1.15 quaternions by a Q3.16 factor along the shorter arc.
// ----------------------------------------------------------------------------
// Usage. An input word carries the start quaternion a, the end quaternion b
// and the blend factor; it is accepted on a rising edge with in_valid and
// in_ready both high. A result word (out_x .. out_w, used_linear) is taken on
// a rising edge with out_valid and out_ready both high. The register
// linear_threshold is written through linear_threshold_we and
// linear_threshold_wdata, which the user must do only while no word is in
// flight; the block itself does not enforce this. One word can be taken every
// cycle while in_ready is high. The depth is set by the one-bit-per-stage
// square root (32) and divider (32) and the 16-iteration CORDIC chains.
// An output register plus one skid entry follow the pipeline; when out_ready
// is low the output holds, the next finished word parks in the skid entry and
// the whole pipeline then freezes with in_ready low until the output drains.
// Nothing is lost or repeated. Reset clears every valid bit, including the
// output and skid flags, and loads linear_threshold with 0.9995 (32752).
// ----------------------------------------------------------------------------
module quaternion_slerp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [qslerp_pkg::CW-1:0]       a_x,
	input  logic signed [qslerp_pkg::CW-1:0]       a_y,
	input  logic signed [qslerp_pkg::CW-1:0]       a_z,
	input  logic signed [qslerp_pkg::CW-1:0]       a_w,
	input  logic signed [qslerp_pkg::CW-1:0]       b_x,
	input  logic signed [qslerp_pkg::CW-1:0]       b_y,
	input  logic signed [qslerp_pkg::CW-1:0]       b_z,
	input  logic signed [qslerp_pkg::CW-1:0]       b_w,
	input  logic signed [qslerp_pkg::BLEND_WIDTH-1:0] blend,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [qslerp_pkg::CW-1:0]       out_x,
	output logic signed [qslerp_pkg::CW-1:0]       out_y,
	output logic signed [qslerp_pkg::CW-1:0]       out_z,
	output logic signed [qslerp_pkg::CW-1:0]       out_w,
	output logic                                   used_linear,
	input  logic                                   linear_threshold_we,
	input  logic [qslerp_pkg::THR_W-1:0]           linear_threshold_wdata
);
	import qslerp_pkg::*;

	// Stage map: s1 dot product, s2 shorter-arc flip and clamp, s3 1-d^2,
	// then square root, arccos, angle products, sines, dividers and the
	// final weighted sum. side_dly_s[k] lines up with stage s3+k.
	localparam int SIDE_DLY  = 1 + SQ_STEPS + CORDIC_STEPS + 1 + CORDIC_STEPS + DIV_LAT;
	localparam int PIPE_LEN  = 3 + SIDE_DLY;
	localparam int PROD_FRAC = 2 * (CW - 1);
	localparam int PSH_R     = (PROD_FRAC >= FRAC) ? PROD_FRAC - FRAC : 0;
	localparam int PSH_L     = (PROD_FRAC >= FRAC) ? 0 : FRAC - PROD_FRAC;
	localparam int PW        = 2 * CW + PSH_L;
	localparam int VOW       = FRAC + CW + 4;
	localparam logic signed [VOW-1:0] RND  = VOW'(1) <<< (FRAC - 1);
	localparam logic signed [VOW-1:0] MAXV = (VOW'(1) <<< (CW - 1)) - VOW'(1);
	localparam logic signed [VOW-1:0] MINV = -MAXV - VOW'(1);

	logic en;
	logic [THR_W-1:0] thr_q;
	logic vld_s [PIPE_LEN];

	logic signed [CW-1:0] a_in [4];
	logic signed [CW-1:0] b_in [4];

	// Stage 1
	blend_t               t_nx;
	logic signed [DOT_W-1:0] dot_nx;
	logic signed [PW-1:0] prod;
	logic signed [CW-1:0] a_s1 [4];
	logic signed [CW-1:0] b_s1 [4];
	blend_t               t_s1;
	logic signed [DOT_W-1:0] dot_s1;

	// Stage 2
	logic signed [DOT_W-1:0] dot_abs;
	wgt_t                 d_nx;
	side_t                side_nx;
	wgt_t                 d_s2;
	side_t                side_s2;

	// Stage 3 onwards
	logic [2*FRAC+1:0]    d_sq;
	logic [60:0]          rest_s3;
	wgt_t                 d_dly_s [SQ_STEPS+1];
	side_t                side_dly_s [SIDE_DLY];
	wgt_t                 root;
	cval_t                acos_z;

	// Angle stage
	cval_t                theta;
	blend_t               t_th;
	blend_t               t_inv;
	logic [VW+17:0]       p1;
	logic [VW+17:0]       p0;
	cval_t                theta_th;
	cval_t                ang0_th;
	cval_t                ang1_th;

	// Sines and weights
	cval_t                sin_th;
	cval_t                sin0;
	cval_t                sin1;
	logic                 small_dly_s [DIV_LAT];
	wgt_t                 q0;
	wgt_t                 q1;

	// Weighted sum stage
	side_t                side_end;
	logic                 lin_f;
	wgt_t                 w0;
	wgt_t                 w1;
	logic signed [VOW-1:0] v_nx [4];
	logic signed [VOW-1:0] v_mul_s [4];
	logic                 lin_mul_s;

	// Output register and skid entry
	logic signed [VOW-1:0] rs [4];
	logic signed [CW-1:0] res [4];
	logic signed [CW-1:0] out_q [4];
	logic signed [CW-1:0] skid_q [4];
	logic                 out_lin_q;
	logic                 skid_lin_q;
	logic                 out_vld_q;
	logic                 skid_vld_q;
	logic                 take;
	logic                 new_word;

	assign a_in[0] = a_x;
	assign a_in[1] = a_y;
	assign a_in[2] = a_z;
	assign a_in[3] = a_w;
	assign b_in[0] = b_x;
	assign b_in[1] = b_y;
	assign b_in[2] = b_z;
	assign b_in[3] = b_w;

	// The pipeline only moves while the skid entry is free.
	assign en       = !skid_vld_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RESET;
		end else if (linear_threshold_we) begin
			thr_q <= linear_threshold_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PIPE_LEN; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < PIPE_LEN; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// Stage 1: clamp the blend factor and form the four-term dot product.
	always_comb begin
		if (blend < 0) begin
			t_nx = '0;
		end else if (blend > $signed(BLEND_WIDTH'(BLEND_ONE))) begin
			t_nx = BLEND_ONE;
		end else begin
			t_nx = blend[16:0];
		end
		dot_nx = '0;
		prod   = '0;
		for (int i = 0; i < 4; i++) begin
			prod   = PW'(a_in[i] * b_in[i]);
			dot_nx = dot_nx + DOT_W'((prod >>> PSH_R) <<< PSH_L);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				a_s1[i] <= a_in[i];
				b_s1[i] <= b_in[i];
			end
			t_s1   <= t_nx;
			dot_s1 <= dot_nx;
		end
	end

	// Stage 2: take the shorter arc, clamp the dot to 1.0 and compare it with
	// the linear threshold.
	always_comb begin
		dot_abs = (dot_s1 < 0) ? -dot_s1 : dot_s1;
		d_nx    = (dot_abs > DOT_W'(ONE_Q30)) ? ONE_W : dot_abs[FRAC:0];
		for (int i = 0; i < 4; i++) begin
			side_nx.a[i] = a_s1[i];
			side_nx.b[i] = (dot_s1 < 0) ? -((CW+1)'(b_s1[i])) : (CW+1)'(b_s1[i]);
		end
		side_nx.t   = t_s1;
		side_nx.lin = (d_nx > {thr_q, 15'b0});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s2    <= d_nx;
			side_s2 <= side_nx;
		end
	end

	// Stage 3: 1 - d^2, the square of the sine of the angle.
	assign d_sq = d_s2 * d_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			rest_s3       <= (61'(1) << 60) - d_sq[60:0];
			d_dly_s[0]    <= d_s2;
			side_dly_s[0] <= side_s2;
			for (int k = 1; k <= SQ_STEPS; k++) d_dly_s[k] <= d_dly_s[k-1];
			for (int k = 1; k < SIDE_DLY; k++) side_dly_s[k] <= side_dly_s[k-1];
		end
	end

	qslerp_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rest (rest_s3),
		.root (root)
	);

	// theta = acos(d) from the vector (d, sqrt(1 - d^2)).
	qslerp_cordic_vec u_acos (
		.clk   (clk),
		.en    (en),
		.x_in  (VW'(d_dly_s[SQ_STEPS])),
		.y_in  (VW'(root)),
		.z_out (acos_z)
	);

	// Angle stage: theta, t*theta and (1-t)*theta, rounded half up to Q2.30.
	always_comb begin
		theta = (acos_z < 0) ? '0 : acos_z;
		t_th  = side_dly_s[SQ_STEPS + CORDIC_STEPS].t;
		t_inv = BLEND_ONE - t_th;
		p1    = (VW+18)'(t_th) * (VW+18)'(theta[VW-2:0]);
		p0    = (VW+18)'(t_inv) * (VW+18)'(theta[VW-2:0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			theta_th <= theta;
			ang1_th  <= VW'((p1 + (VW+18)'(32768)) >> 16);
			ang0_th  <= VW'((p0 + (VW+18)'(32768)) >> 16);
		end
	end

	// The three sines share the CORDIC gain, which cancels in the division.
	qslerp_cordic_rot u_sin_th (
		.clk     (clk),
		.en      (en),
		.z_in    (theta_th),
		.sin_out (sin_th)
	);

	qslerp_cordic_rot u_sin0 (
		.clk     (clk),
		.en      (en),
		.z_in    (ang0_th),
		.sin_out (sin0)
	);

	qslerp_cordic_rot u_sin1 (
		.clk     (clk),
		.en      (en),
		.z_in    (ang1_th),
		.sin_out (sin1)
	);

	qslerp_div u_div0 (
		.clk (clk),
		.en  (en),
		.num (sin0),
		.den (sin_th),
		.quo (q0)
	);

	qslerp_div u_div1 (
		.clk (clk),
		.en  (en),
		.num (sin1),
		.den (sin_th),
		.quo (q1)
	);

	// A near-zero sine means the angle is degenerate: fall back to linear.
	always_ff @(posedge clk) begin
		if (en) begin
			small_dly_s[0] <= (sin_th < SIN_FLOOR);
			for (int k = 1; k < DIV_LAT; k++) small_dly_s[k] <= small_dly_s[k-1];
		end
	end

	// Weighted sum stage: w0*a + w1*b per component, linear weights under lin_f.
	always_comb begin
		side_end = side_dly_s[SIDE_DLY-1];
		lin_f    = side_end.lin || small_dly_s[DIV_LAT-1];
		w0       = lin_f ? (wgt_t'(BLEND_ONE - side_end.t) << 14) : q0;
		w1       = lin_f ? (wgt_t'(side_end.t) << 14) : q1;
		for (int i = 0; i < 4; i++) begin
			v_nx[i] = $signed({1'b0, w0}) * $signed(side_end.a[i])
			        + $signed({1'b0, w1}) * $signed(side_end.b[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) v_mul_s[i] <= v_nx[i];
			lin_mul_s <= lin_f;
		end
	end

	// Round half up to Q1.15 and saturate.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rs[i] = (v_mul_s[i] + RND) >>> FRAC;
			if (rs[i] > MAXV) begin
				res[i] = CW'(MAXV);
			end else if (rs[i] < MINV) begin
				res[i] = CW'(MINV);
			end else begin
				res[i] = CW'(rs[i]);
			end
		end
	end

	assign take     = out_vld_q && out_ready;
	assign new_word = en && vld_s[PIPE_LEN-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (new_word) begin
			if (!out_vld_q || take) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				for (int i = 0; i < 4; i++) out_q[i] <= skid_q[i];
				out_lin_q <= skid_lin_q;
			end
		end else if (new_word) begin
			if (!out_vld_q || take) begin
				for (int i = 0; i < 4; i++) out_q[i] <= res[i];
				out_lin_q <= lin_mul_s;
			end else begin
				for (int i = 0; i < 4; i++) skid_q[i] <= res[i];
				skid_lin_q <= lin_mul_s;
			end
		end
	end

	assign out_valid   = out_vld_q;
	assign out_x       = out_q[0];
	assign out_y       = out_q[1];
	assign out_z       = out_q[2];
	assign out_w       = out_q[3];
	assign used_linear = out_lin_q;

endmodule

// ===== tb/sv/quaternion_slerp_tb.sv =====
// ----------------------------------------------------------------------------
// quaternion_slerp_tb: self-checking bench for the quaternion slerp pipeline
// Drives quaternion pairs and blend factors under random idling on both
// channels, predicts each result word in fixed point and checks it field by
// field against the oldest prediction, across several threshold settings.
// ----------------------------------------------------------------------------
module quaternion_slerp_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import qslerp_pkg::*;

	localparam int  MAX_CYCLES = 2000000;
	localparam int  LATENCY    = 101;
	localparam int  N_RANDOM   = 1230;
	localparam int  Q30        = 30;
	localparam longint ONE     = 64'sd1 << Q30;
	localparam longint FLOOR_S = 64'sd1 << 16;

	// One result word as the block should present it.
	typedef struct packed {
		logic [15:0] x, y, z, w;
		logic        lin;
	} slerp_word_t;

	// Scoreboard: a queue of predicted words, consumed in order.
	class slerp_scoreboard;
		slerp_word_t pending[$];
		int          errors;

		function void note_input(slerp_word_t w);
			pending.push_back(w);
		endfunction

		function void check_result(slerp_word_t got);
			slerp_word_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.x !== want.x) begin
				$display("%0t: out_x expected %h actual %h", $time, want.x, got.x);
				errors++;
			end
			if (got.y !== want.y) begin
				$display("%0t: out_y expected %h actual %h", $time, want.y, got.y);
				errors++;
			end
			if (got.z !== want.z) begin
				$display("%0t: out_z expected %h actual %h", $time, want.z, got.z);
				errors++;
			end
			if (got.w !== want.w) begin
				$display("%0t: out_w expected %h actual %h", $time, want.w, got.w);
				errors++;
			end
			if (got.lin !== want.lin) begin
				$display("%0t: used_linear expected %b actual %b", $time, want.lin,
					got.lin);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] a_x = '0, a_y = '0, a_z = '0, a_w = '0;
	logic signed [15:0] b_x = '0, b_y = '0, b_z = '0, b_w = '0;
	logic signed [18:0] blend = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] out_x, out_y, out_z, out_w;
	logic used_linear;
	logic thr_we = 1'b0;
	logic [15:0] thr_wdata = '0;

	slerp_scoreboard sb;
	logic [15:0] thr_shadow;   // the bench's copy of linear_threshold
	bit          long_hold;    // asks the receiver for one long stall
	longint      cycles;

	always #10 clk = ~clk;

	quaternion_slerp u_dut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.in_valid               (in_valid),
		.in_ready               (in_ready),
		.a_x                    (a_x),
		.a_y                    (a_y),
		.a_z                    (a_z),
		.a_w                    (a_w),
		.b_x                    (b_x),
		.b_y                    (b_y),
		.b_z                    (b_z),
		.b_w                    (b_w),
		.blend                  (blend),
		.out_valid              (out_valid),
		.out_ready              (out_ready),
		.out_x                  (out_x),
		.out_y                  (out_y),
		.out_z                  (out_z),
		.out_w                  (out_w),
		.used_linear            (used_linear),
		.linear_threshold_we    (thr_we),
		.linear_threshold_wdata (thr_wdata)
	);

	// Floor shift right, valid for negative values as well.
	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint atan_q30(int i);
		longint tab[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149};
		if (i < 10)
			return tab[i];
		return 64'sd1 << (Q30 - i);
	endfunction

	// Rotation CORDIC; the result still carries the CORDIC gain, which cancels
	// in the ratio of two such values.
	function automatic longint rot_sin(longint ang);
		longint cx, cy, dx, dy;
		cx = ONE;
		cy = 0;
		for (int i = 0; i < 16; i++) begin
			dx = floor_shr(cy, i);
			dy = floor_shr(cx, i);
			if (ang >= 0) begin
				cx -= dx; cy += dy; ang -= atan_q30(i);
			end else begin
				cx += dx; cy -= dy; ang += atan_q30(i);
			end
		end
		return cy;
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned rem, root, bitv;
		rem = n;
		root = 0;
		bitv = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (rem >= root + bitv) begin
				rem -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(root);
	endfunction

	// Arc cosine by square root of 1-d^2 and a vectoring CORDIC.
	function automatic longint arc_cos(longint d);
		longint vx, vy, vz, dx, dy;
		vx = d;
		vy = int_sqrt((64'd1 << 60) - longint'(d * d));
		vz = 0;
		for (int i = 0; i < 16; i++) begin
			dx = floor_shr(vy, i);
			dy = floor_shr(vx, i);
			if (vy >= 0) begin
				vx += dx; vy -= dy; vz += atan_q30(i);
			end else begin
				vx -= dx; vy += dy; vz -= atan_q30(i);
			end
		end
		return (vz < 0) ? 0 : vz;
	endfunction

	function automatic longint sin_ratio(longint num, longint den);
		longint unsigned q;
		if (num <= 0)
			return 0;
		q = ((longint'(num) << Q30) + den / 2) / den;
		return (q > ONE) ? ONE : longint'(q);
	endfunction

	function automatic slerp_word_t predict_slerp(logic [15:0] qa[4], logic [15:0] qb[4],
		logic [18:0] bl, logic [15:0] thr);
		slerp_word_t res;
		longint av[4], bv[4], t, dot, w0, w1, theta, sth, v, r;
		bit lin;
		dot = 0;
		for (int i = 0; i < 4; i++) begin
			av[i] = longint'(signed'(qa[i]));
			bv[i] = longint'(signed'(qb[i]));
			dot += av[i] * bv[i];   // Q2.30 already for 16-bit components
		end
		t = longint'(signed'(bl));
		if (t < 0) t = 0;
		if (t > 65536) t = 65536;
		// Shorter arc: flip b when the quaternions point apart.
		if (dot < 0) begin
			dot = -dot;
			for (int i = 0; i < 4; i++) bv[i] = -bv[i];
		end
		if (dot > ONE) dot = ONE;
		lin = dot > (longint'(thr) << 15);
		w0 = 0;
		w1 = 0;
		if (!lin) begin
			theta = arc_cos(dot);
			sth = rot_sin(theta);
			// Degenerate angle falls back to the linear weights.
			if (sth < FLOOR_S) begin
				lin = 1'b1;
			end else begin
				w1 = sin_ratio(rot_sin((t * theta + 32768) >>> 16), sth);
				w0 = sin_ratio(rot_sin(((65536 - t) * theta + 32768) >>> 16), sth);
			end
		end
		if (lin) begin
			w1 = t << 14;
			w0 = (65536 - t) << 14;
		end
		for (int i = 0; i < 4; i++) begin
			v = w0 * av[i] + w1 * bv[i];
			r = (v + (64'sd1 << 29)) >>> Q30;
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			case (i)
				0: res.x = r[15:0];
				1: res.y = r[15:0];
				2: res.z = r[15:0];
				default: res.w = r[15:0];
			endcase
		end
		res.lin = lin;
		return res;
	endfunction

	// Offers one word and holds it until the block takes it; the prediction
	// is noted at the accepting edge. Valid only drops when a gap follows, so
	// back-to-back words keep it high.
	task automatic send_word(logic [15:0] qa[4], logic [15:0] qb[4], logic [18:0] bl);
		int gap;
		gap = ($urandom_range(0, 9) < 6) ? 0 :
			(($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		a_x <= qa[0]; a_y <= qa[1]; a_z <= qa[2]; a_w <= qa[3];
		b_x <= qb[0]; b_y <= qb[1]; b_z <= qb[2]; b_w <= qb[3];
		blend <= bl;
		do @(posedge clk); while (!in_ready);
		sb.note_input(predict_slerp(qa, qb, bl, thr_shadow));
	endtask

	// Waits until every predicted word has arrived, then lets the pipe drain.
	task automatic drain_all();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic set_threshold(logic [15:0] value);
		thr_we <= 1'b1;
		thr_wdata <= value;
		@(posedge clk);
		thr_we <= 1'b0;
		thr_shadow = value;
	endtask

	// Random unit-ish quaternion, mostly well-formed, sometimes raw noise.
	task automatic rand_quat(output logic [15:0] q[4]);
		int sel;
		sel = $urandom_range(0, 9);
		for (int i = 0; i < 4; i++)
			q[i] = (sel < 7) ? 16'(int'($urandom_range(0, 32767)) - 16384) : 16'($urandom);
	endtask

	// Near neighbour of a, optionally mirrored, to exercise tiny angles.
	task automatic near_quat(logic [15:0] qa[4], output logic [15:0] q[4]);
		bit flip;
		flip = $urandom_range(0, 1);
		for (int i = 0; i < 4; i++) begin
			q[i] = qa[i] + 16'(int'($urandom_range(0, 64)) - 32);
			if (flip) q[i] = -q[i];
		end
	endtask

	function automatic logic [18:0] rand_blend();
		case ($urandom_range(0, 9))
			0: return 19'($urandom);
			1: return 19'd0;
			2: return 19'd65536;
			default: return 19'($urandom_range(0, 65536));
		endcase
	endfunction

	// Receiver: random stalls, one long hold when asked.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				long_hold = 0;
			end
			if ($urandom_range(0, 9) < 7) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : 0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Results are sampled at the accepting edge.
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result({out_x, out_y, out_z, out_w, used_linear});

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [15:0] qa[4], qb[4];
		logic [15:0] thr_set[5] = '{16'd0, 16'd32768, 16'd65535, 16'd30000, 16'd32752};
		sb = new();
		cycles = 0;
		long_hold = 0;
		thr_shadow = THRESH_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, identical and opposite quaternions, blend limits.
		qa = '{16'h7fff, 16'h0, 16'h0, 16'h0};
		send_word(qa, qa, 19'd0);
		send_word(qa, qa, 19'h7ffff);            // negative blend clamps to 0
		send_word(qa, qa, 19'h3ffff);            // blend above 1.0 clamps
		qb = '{16'h0, 16'h7fff, 16'h0, 16'h0};
		send_word(qa, qb, 19'd32768);            // right angle, spherical
		send_word(qa, qb, 19'd65536);
		qb = '{16'h8000, 16'h0, 16'h0, 16'h0};
		send_word(qa, qb, 19'd16384);            // negative dot, shorter arc
		qa = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
		send_word(qa, qa, 19'd40000);            // oversized dot clamps to 1
		qb = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
		send_word(qa, qb, 19'h40000);
		qa = '{16'h5a82, 16'h5a82, 16'h0, 16'h0};
		qb = '{16'h5a83, 16'h5a81, 16'h0, 16'h0};
		send_word(qa, qb, 19'd20000);            // tiny angle, above the linear threshold
		qa = '{16'h0, 16'h0, 16'h0, 16'h0};
		send_word(qa, qb, 19'd1);
		qa = '{16'h4000, 16'h4000, 16'h4000, 16'h4000};
		qb = '{16'h4000, 16'hc000, 16'h4000, 16'hc000};
		send_word(qa, qb, 19'd49152);            // orthogonal unit quaternions

		// Random phases, each under its own threshold.
		for (int ph = 0; ph < 5; ph++) begin
			drain_all();
			set_threshold(thr_set[ph]);
			if (ph == 1) long_hold = 1;       // fills the pipe and the skid entry
			for (int n = 0; n < N_RANDOM / 5; n++) begin
				rand_quat(qa);
				if ($urandom_range(0, 3) == 0) near_quat(qa, qb);
				else rand_quat(qb);
				send_word(qa, qb, rand_blend());
				if (n == 120) drain_all();      // sender pauses until all have come
			end
		end

		drain_all();
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
